// ----- hdl/rgb_convolution_3x3_top_assert.svh -----
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_top_assert
// Assertion macros for the 3x3 RGB convolution filter.
// ----------------------------------------------------------------------------
`ifndef RGB_CONVOLUTION_3X3_TOP_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RCV_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RCV_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define RCV_ASSERT_IMPL(label, clk, rst_n, prop)
`define RCV_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- hdl/rcv_pkg.sv -----
// ----------------------------------------------------------------------------
// rcv_pkg
// Types and constants shared by the 3x3 RGB convolution filter.
// ----------------------------------------------------------------------------
package rcv_pkg;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } rcv_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       frame_done;
  } rcv_out_t;

  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 48;
  localparam int unsigned SumBits = 30;
  localparam int unsigned DivBits = 12;
  localparam int unsigned GeomBits = 11;
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned MaxHeight = 1024;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_COEF_TOP = 3'd0,
    REG_COEF_MID = 3'd1,
    REG_COEF_BOT = 3'd2,
    REG_DIVISOR  = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } rcv_reg_t;

  typedef struct packed {
    logic                      start;
    logic signed [SumBits-1:0] dividend;
    logic [DivBits-1:0]        divisor;
  } rcv_div_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] value;
  } rcv_div_rsp_t;

endpackage

// ----- hdl/rcv_divider.sv -----
// ----------------------------------------------------------------------------
// rcv_divider
// Restoring divider, one quotient bit per cycle, truncating toward zero,
// with the quotient clamped to 0..255.
// ----------------------------------------------------------------------------
module rcv_divider
  import rcv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  rcv_div_req_t req,
  output rcv_div_rsp_t rsp
);

  localparam int unsigned CntBits = $clog2(SumBits + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic [SumBits-1:0] quo_r, quo_nxt;
  logic [DivBits:0]   rem_r, rem_nxt;
  logic [DivBits-1:0] den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic [DivBits:0]   trial;
  logic [DivBits:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    trial    = {rem_r[DivBits-1:0], quo_r[SumBits-1]};
    diff     = trial - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntBits'(SumBits);
      neg_nxt  = req.dividend[SumBits-1];
      quo_nxt  = req.dividend[SumBits-1] ? SumBits'(-req.dividend)
                                         : SumBits'(req.dividend);
      rem_nxt  = '0;
      den_nxt  = (req.divisor == '0) ? DivBits'(1) : req.divisor;
    end else if (busy_r) begin
      if (!diff[DivBits]) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[SumBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SumBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntBits'(1);
      if (cnt_r == CntBits'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.value = (neg_r || quo_r == '0) ? 8'd0 :
                     (quo_r > SumBits'(255)) ? 8'd255 : quo_r[7:0];

endmodule

// ----- hdl/rgb_convolution_3x3_top.sv -----
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_top
// Pixels are taken one at a time: in_stall is high until the current one is done.
// A border pixel passes READ only; an interior pixel then runs nine MAC taps, DIV
// and WAIT on the divider's quotient bits for each channel, then holds in OUT.
// Reset: synchronous active low; counters, window and coefficients clear,
// divisor to 1, geometry to 1024; line buffers hold unknown data until written.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_top
  import rcv_pkg::*;
#(
  parameter int unsigned COEF_BITS = 16
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rcv_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rcv_out_t               out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxBits-1:0]  cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data
);

`include "rgb_convolution_3x3_top_assert.svh"

  localparam int unsigned AddrBits = $clog2(MaxWidth);
  localparam int unsigned PosBits = 10;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CfgDataBits-1:0] coef_r [3];
  logic [DivBits-1:0]     div_r;
  logic [GeomBits-1:0]    width_r, height_r;

  logic [23:0] lb_a [MaxWidth];
  logic [23:0] lb_b [MaxWidth];
  logic [23:0] rd_a_r, rd_b_r;

  logic [23:0] win_r [3][3];
  logic [PosBits-1:0] row_r, col_r;
  logic [PosBits-1:0] rcur_r, ccur_r;
  logic [23:0] pix_r;
  logic        emit_r, last_r;

  logic [GeomBits-1:0] w_eff, h_eff;
  logic [PosBits-1:0]  r_cur, c_cur;
  logic [3:0]          tap_r;
  logic [1:0]          ch_r;
  logic signed [SumBits-1:0] acc_r;
  logic [7:0]          res_r [3];
  rcv_div_req_t        dreq;
  rcv_div_rsp_t        drsp;
  logic                in_acc;
  logic                cfg_acc;

  always_comb begin
    w_eff = width_r;
    if (width_r < GeomBits'(3)) w_eff = GeomBits'(3);
    if (width_r > GeomBits'(MaxWidth)) w_eff = GeomBits'(MaxWidth);
    h_eff = height_r;
    if (height_r < GeomBits'(3)) h_eff = GeomBits'(3);
    if (height_r > GeomBits'(MaxHeight)) h_eff = GeomBits'(MaxHeight);
    r_cur = ({1'b0, row_r} >= h_eff) ? '0 : row_r;
    c_cur = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= '0;
      coef_r[1] <= '0;
      coef_r[2] <= '0;
      div_r     <= DivBits'(1);
      width_r   <= GeomBits'(1024);
      height_r  <= GeomBits'(1024);
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_COEF_TOP: coef_r[0] <= cfg_data;
        REG_COEF_MID: coef_r[1] <= cfg_data;
        REG_COEF_BOT: coef_r[2] <= cfg_data;
        REG_DIVISOR:  div_r <= cfg_data[DivBits-1:0];
        REG_WIDTH:    width_r <= cfg_data[GeomBits-1:0];
        REG_HEIGHT:   height_r <= cfg_data[GeomBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_a_r <= lb_a[c_cur[AddrBits-1:0]];
      rd_b_r <= lb_b[c_cur[AddrBits-1:0]];
    end
    if (state_r == ST_READ) begin
      lb_a[ccur_r[AddrBits-1:0]] <= pix_r;
      lb_b[ccur_r[AddrBits-1:0]] <= rd_a_r;
    end
  end

  logic signed [COEF_BITS-1:0] coef_sel;
  logic [7:0]                  samp_sel;
  logic signed [SumBits-1:0]   prod;
  logic [1:0] ti, tj;

  always_comb begin
    unique case (tap_r)
      4'd0: begin ti = 2'd0; tj = 2'd0; end
      4'd1: begin ti = 2'd0; tj = 2'd1; end
      4'd2: begin ti = 2'd0; tj = 2'd2; end
      4'd3: begin ti = 2'd1; tj = 2'd0; end
      4'd4: begin ti = 2'd1; tj = 2'd1; end
      4'd5: begin ti = 2'd1; tj = 2'd2; end
      4'd6: begin ti = 2'd2; tj = 2'd0; end
      4'd7: begin ti = 2'd2; tj = 2'd1; end
      default: begin ti = 2'd2; tj = 2'd2; end
    endcase
    coef_sel = coef_r[ti][16*tj +: COEF_BITS];
    samp_sel = win_r[ti][tj][8*ch_r +: 8];
    prod = SumBits'(coef_sel) * SumBits'($signed({1'b0, samp_sel}));
  end

  assign dreq.start    = (state_r == ST_MAC) && (tap_r == 4'd8);
  assign dreq.dividend = acc_r + prod;
  assign dreq.divisor  = div_r;

  rcv_divider u_div (
    .clk(clk),
    .rst_n(rst_n),
    .req(dreq),
    .rsp(drsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_READ;
      ST_READ: state_nxt = emit_r ? ST_MAC : ST_IDLE;
      ST_MAC:  if (tap_r == 4'd8) state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_WAIT;
      ST_WAIT: if (drsp.done) state_nxt = (ch_r == 2'd2) ? ST_OUT : ST_MAC;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      tap_r   <= '0;
      ch_r    <= '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win_r[i][j] <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        pix_r  <= {in_data.in_blue, in_data.in_green, in_data.in_red};
        rcur_r <= r_cur;
        ccur_r <= c_cur;
        emit_r <= (r_cur >= PosBits'(2)) && (c_cur >= PosBits'(2));
        last_r <= ({1'b0, r_cur} == h_eff - GeomBits'(1)) &&
                  ({1'b0, c_cur} == w_eff - GeomBits'(1));
        if ({1'b0, c_cur} + GeomBits'(1) >= w_eff) begin
          col_r <= '0;
          row_r <= ({1'b0, r_cur} + GeomBits'(1) >= h_eff) ? '0
                                                          : r_cur + PosBits'(1);
        end else begin
          col_r <= c_cur + PosBits'(1);
          row_r <= r_cur;
        end
      end
      if (state_r == ST_READ) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= rd_b_r;
        win_r[1][2] <= rd_a_r;
        win_r[2][2] <= pix_r;
        tap_r <= '0;
        ch_r  <= '0;
        acc_r <= '0;
      end
      if (state_r == ST_MAC) begin
        acc_r <= acc_r + prod;
        tap_r <= (tap_r == 4'd8) ? 4'd0 : tap_r + 4'd1;
      end
      if (state_r == ST_WAIT && drsp.done) begin
        res_r[ch_r] <= drsp.value;
        acc_r <= '0;
        if (ch_r != 2'd2) ch_r <= ch_r + 2'd1;
      end
    end
  end

  assign out_valid           = (state_r == ST_OUT);
  assign out_data.out_red    = res_r[0];
  assign out_data.out_green  = res_r[1];
  assign out_data.out_blue   = res_r[2];
  assign out_data.out_row    = rcur_r - PosBits'(1);
  assign out_data.out_col    = ccur_r - PosBits'(1);
  assign out_data.frame_done = last_r;

  `RCV_ASSERT_NEVER(a_no_dual, clk, rst_n, in_acc && out_valid)
  `RCV_ASSERT_IMPL(a_out_hold, clk, rst_n,
    (out_valid && out_stall) |=> out_valid && $stable(out_data))
  `RCV_ASSERT_NEVER(a_cfg_busy, clk, rst_n, cfg_ready && drsp.busy)

endmodule

// ----- bench/rgb_convolution_3x3_top_tb.sv -----
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_top_tb
// Streams RGB frames through the 3x3 convolution filter, predicts each
// filtered interior pixel from a local copy of the line buffers, window and
// registers, and checks every result in order under random idling and stalls.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_top_tb;
  import rcv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles = 120;
  localparam longint unsigned CycleLimit = 1000000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  rcv_in_t                in_data;
  logic                   out_valid;
  logic                   out_stall;
  rcv_out_t               out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index;
  logic [CfgDataBits-1:0] cfg_data;

  rgb_convolution_3x3_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [47:0]       coef_rows [3];
  logic [11:0]       div_reg;
  logic [10:0]       width_reg;
  logic [10:0]       height_reg;
  logic [23:0]       prev_row [MaxWidth];
  logic [23:0]       prev_prev_row [MaxWidth];
  logic [23:0]       window [3][3];
  int unsigned       row_pos;
  int unsigned       col_pos;
  rcv_out_t          filtered_q [$];
  int unsigned       error_count;
  int unsigned       pixels_sent;
  longint unsigned   cycle_count = 0;
  bit                calm;
  int unsigned       hold_len;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always begin
    @(negedge clk);
    if (hold_len > 0) begin
      out_stall = 1'b1;
      repeat (hold_len) @(negedge clk);
      hold_len = 0;
    end
    out_stall = !calm && ($urandom_range(0, 99) < 7);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected filtered pixel row=%0d col=%0d", out_data.out_row,
               out_data.out_col);
        error_count++;
      end else begin
        rcv_out_t exp_px;
        exp_px = filtered_q.pop_front();
        if (out_data.out_red !== exp_px.out_red) begin
          $error("out_red expected %0d actual %0d", exp_px.out_red, out_data.out_red);
          error_count++;
        end
        if (out_data.out_green !== exp_px.out_green) begin
          $error("out_green expected %0d actual %0d", exp_px.out_green,
                 out_data.out_green);
          error_count++;
        end
        if (out_data.out_blue !== exp_px.out_blue) begin
          $error("out_blue expected %0d actual %0d", exp_px.out_blue, out_data.out_blue);
          error_count++;
        end
        if (out_data.out_row !== exp_px.out_row) begin
          $error("out_row expected %0d actual %0d", exp_px.out_row, out_data.out_row);
          error_count++;
        end
        if (out_data.out_col !== exp_px.out_col) begin
          $error("out_col expected %0d actual %0d", exp_px.out_col, out_data.out_col);
          error_count++;
        end
        if (out_data.frame_done !== exp_px.frame_done) begin
          $error("frame_done expected %0d actual %0d", exp_px.frame_done,
                 out_data.frame_done);
          error_count++;
        end
      end
    end
  end

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > MaxHeight) return MaxHeight;
    return height_reg;
  endfunction

  function automatic logic [7:0] filter_channel(int unsigned sh);
    longint acc;
    logic signed [15:0] k;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        k = coef_rows[i][16*j +: 16];
        acc += longint'(k) * longint'({56'd0, window[i][j][sh +: 8]});
      end
    end
    acc = acc / longint'((div_reg == 0) ? 1 : div_reg);
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  task automatic filter_pixel(input rcv_in_t px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    logic [23:0] p;
    logic [23:0] top;
    logic [23:0] mid;
    rcv_out_t res;
    w = eff_width();
    h = eff_height();
    r = (row_pos >= h) ? 0 : row_pos;
    c = (col_pos >= w) ? 0 : col_pos;
    p = {px.in_blue, px.in_green, px.in_red};
    top = prev_prev_row[c];
    mid = prev_row[c];
    prev_prev_row[c] = mid;
    prev_row[c] = p;
    for (int i = 0; i < 3; i++) begin
      window[i][0] = window[i][1];
      window[i][1] = window[i][2];
    end
    window[0][2] = top;
    window[1][2] = mid;
    window[2][2] = p;
    if (r >= 2 && c >= 2) begin
      res.out_red = filter_channel(0);
      res.out_green = filter_channel(8);
      res.out_blue = filter_channel(16);
      res.out_row = 10'(r - 1);
      res.out_col = 10'(c - 1);
      res.frame_done = (r == h - 1) && (c == w - 1);
      filtered_q.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic send_pixel(input rcv_in_t px);
    if (!calm && ($urandom_range(0, 99) < 7)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = px;
    do @(posedge clk); while (in_stall);
    filter_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (filtered_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input rcv_reg_t idx, input logic [47:0] value);
    drain();
    repeat (SettleCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COEF_TOP: coef_rows[0] = value;
      REG_COEF_MID: coef_rows[1] = value;
      REG_COEF_BOT: coef_rows[2] = value;
      REG_DIVISOR:  div_reg = value[11:0];
      REG_WIDTH:    width_reg = value[10:0];
      REG_HEIGHT:   height_reg = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [47:0] pack_coefs(int left, int centre, int right);
    return {16'(right), 16'(centre), 16'(left)};
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic logic [11:0] rand_divisor();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'($urandom);
      default: return 12'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic set_filter(input logic [47:0] top, input logic [47:0] mid,
                            input logic [47:0] bot, input logic [11:0] dv);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOT, bot);
    write_reg(REG_DIVISOR, {36'd0, dv});
  endtask

  task automatic set_random_filter();
    set_filter({rand_coef(), rand_coef(), rand_coef()},
               {rand_coef(), rand_coef(), rand_coef()},
               {rand_coef(), rand_coef(), rand_coef()}, rand_divisor());
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(REG_WIDTH, 48'(w));
    write_reg(REG_HEIGHT, 48'(h));
  endtask

  // Kind 0 is random, 1 all full scale, 2 all black, 3 alternating black and white.
  task automatic send_frame(input int kind, input bit pause_mid);
    int unsigned w;
    int unsigned h;
    rcv_in_t px;
    w = eff_width();
    h = eff_height();
    for (int unsigned r = 0; r < h; r++) begin
      if (pause_mid && r == h / 2) drain();
      for (int unsigned c = 0; c < w; c++) begin
        case (kind)
          1: px = '1;
          2: px = '0;
          3: px = ((r + c) % 2 == 1) ? '1 : '0;
          default: px = rcv_in_t'(24'($urandom));
        endcase
        send_pixel(px);
      end
    end
  endtask

  task automatic test_identity();
    set_geometry(3, 3);
    set_filter(48'd0, pack_coefs(0, 1, 0), 48'd0, 12'd1);
    send_frame(0, 1'b0);
  endtask

  task automatic test_clamp_high();
    set_geometry(0, 2);
    set_filter({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, 12'd0);
    send_frame(1, 1'b0);
    set_filter({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, 12'd4095);
    send_frame(3, 1'b0);
  endtask

  task automatic test_clamp_low();
    set_geometry(3, 0);
    set_filter({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 12'd4095);
    send_frame(1, 1'b0);
    send_frame(2, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned frame_idx;
    frame_idx = 0;
    while (pixels_sent < 350) begin
      set_geometry($urandom_range(3, 10), $urandom_range(3, 6));
      set_random_filter();
      calm = (frame_idx >= 3 && frame_idx < 6);
      send_frame(($urandom_range(0, 9) == 0) ? 3 : 0, $urandom_range(0, 3) == 0);
      frame_idx++;
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    set_geometry(8, 8);
    set_filter(pack_coefs(1, 2, 1), pack_coefs(2, 4, 2), pack_coefs(1, 2, 1), 12'd16);
    calm = 1'b1;
    hold_len = 600;
    send_frame(0, 1'b0);
    calm = 1'b0;
  endtask

  task automatic test_largest_geometry();
    set_geometry(3, 2047);
    set_filter(pack_coefs(-1, -1, -1), pack_coefs(-1, 9, -1),
               pack_coefs(-1, -1, -1), 12'd1);
    for (int n = 0; n < 36; n++) begin
      send_pixel(rcv_in_t'(24'($urandom)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    coef_rows = '{48'd0, 48'd0, 48'd0};
    div_reg = 12'd1;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    window = '{default: '0};
    row_pos = 0;
    col_pos = 0;
    error_count = 0;
    pixels_sent = 0;
    calm = 1'b0;
    hold_len = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_identity();
    test_clamp_high();
    test_clamp_low();
    test_backpressure();
    test_random_frames();
    test_largest_geometry();

    drain();
    repeat (SettleCycles) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- rgb_convolution_3x3_top.f -----
+incdir+hdl
hdl/rcv_pkg.sv
hdl/rcv_divider.sv
hdl/rgb_convolution_3x3_top.sv
bench/rgb_convolution_3x3_top_tb.sv
